// File: rtl/core/gipb_pkg.sv
// Package for the Gaussian image pyramid builder.
// Holds the beat types, action codes, store geometry and weight tables.
// No dependencies.
package gipb_pkg;

  localparam int MaxRows    = 128;
  localparam int MaxCols    = 128;
  localparam int MaxLevels  = 7;
  localparam int PixelBits  = 16;
  localparam int RowBits    = 7;
  localparam int ColBits    = 7;
  localparam int StoreDepth = 21845;
  localparam int AddrBits   = 15;
  localparam int AccBits    = PixelBits + 8;

  localparam logic [1:0] ActLoad  = 2'd0;
  localparam logic [1:0] ActBuild = 2'd1;
  localparam logic [1:0] ActRead  = 2'd2;
  localparam logic [1:0] ActNone  = 2'd3;

  localparam logic [1:0] RegBaseRows   = 2'd0;
  localparam logic [1:0] RegBaseCols   = 2'd1;
  localparam logic [1:0] RegLevelCount = 2'd2;

  typedef struct packed {
    logic [1:0]           action;
    logic [2:0]           level;
    logic [RowBits-1:0]   row;
    logic [ColBits-1:0]   col;
    logic [PixelBits-1:0] pixel_in;
  } cmd_t;

  typedef struct packed {
    logic                 is_read_data;
    logic [PixelBits-1:0] pixel_out;
    logic [7:0]           level_rows;
    logic [7:0]           level_cols;
    logic                 out_of_range;
  } res_t;

  // Base address of each level, each packed at its maximal size.
  function automatic logic [AddrBits-1:0] level_offset(input logic [2:0] k);
    logic [AddrBits-1:0] o;
    case (k)
      3'd0:    o = AddrBits'(0);
      3'd1:    o = AddrBits'(16384);
      3'd2:    o = AddrBits'(20480);
      3'd3:    o = AddrBits'(21504);
      3'd4:    o = AddrBits'(21760);
      3'd5:    o = AddrBits'(21824);
      3'd6:    o = AddrBits'(21840);
      3'd7:    o = AddrBits'(21844);
      default: o = AddrBits'(0);
    endcase
    return o;
  endfunction

  function automatic logic [2:0] binom(input logic [2:0] d);
    logic [2:0] b;
    case (d)
      3'd0:    b = 3'd1;
      3'd1:    b = 3'd4;
      3'd2:    b = 3'd6;
      3'd3:    b = 3'd4;
      3'd4:    b = 3'd1;
      default: b = 3'd0;
    endcase
    return b;
  endfunction

  function automatic logic [5:0] weight(input logic [2:0] dy, input logic [2:0] dx);
    logic [5:0] w;
    w = 6'(binom(dy)) * 6'(binom(dx));
    return w;
  endfunction

endpackage

// File: rtl/core/gaussian_image_pyramid_builder.sv
// Top level of the Gaussian image pyramid builder.
// Depends on gipb_pkg and gipb_store.
//
// A load gives no result. A read's result appears on the cycle after the read is taken.
// A build holds busy_o while every 5x5 tap of each reduced pixel goes through the
// single read port of the pixel store; the build-done result follows the last write.
// Results carry no backpressure: each is shown for exactly one cycle with res_strobe_o.
module gaussian_image_pyramid_builder (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  gipb_pkg::cmd_t cmd_i,
  output logic           res_strobe_o,
  output gipb_pkg::res_t res_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [1:0]     cfg_index_i,
  input  logic [7:0]     cfg_data_i
);
  import gipb_pkg::*;

  localparam logic [1:0] SIdle  = 2'd0;
  localparam logic [1:0] SRun   = 2'd1;
  localparam logic [1:0] SDrain = 2'd2;

  logic [1:0] state_q, state_d;
  logic [7:0] base_rows_q, base_cols_q;
  logic [2:0] level_count_q;
  logic [7:0] rows_q [MaxLevels+1];
  logic [7:0] cols_q [MaxLevels+1];
  logic [7:0] rows_d [MaxLevels+1];
  logic [7:0] cols_d [MaxLevels+1];
  logic [2:0] lvl_q, lvl_d, lc_q;
  logic [RowBits-1:0] i_q, i_d;
  logic [ColBits-1:0] j_q, j_d;
  logic [2:0] dy_q, dy_d, dx_q, dx_d;

  logic                tap_vld_q, first_q, last_q;
  logic [5:0]          w_q;
  logic [AddrBits-1:0] waddr_q;
  logic [AccBits-1:0]  acc_q, mac;
  logic [AccBits:0]    rnd;

  logic                rd_pend_q, rd_oor_q, done_q;
  logic [7:0]          rd_rows_q, rd_cols_q;

  logic accept, is_load, is_build, is_read, cfg_we;
  logic [7:0] br, bc, rr, cc;
  logic [2:0] lc;
  logic [7:0] cur_rows, cur_cols, yend, xend, vy, vx, y, x;
  logic [2:0] src;
  logic [AddrBits-1:0] src_addr, dst_addr, rd_addr;
  logic [AddrBits-1:0] mem_waddr, mem_raddr;
  logic [PixelBits-1:0] mem_wdata, rdata;
  logic mem_we, build_wr;
  logic [7:0] q_rows, q_cols;

  assign accept   = start_i && !busy_o;
  assign is_load  = accept && (cmd_i.action == ActLoad);
  assign is_build = accept && (cmd_i.action == ActBuild);
  assign is_read  = accept && (cmd_i.action == ActRead);
  assign busy_o   = (state_q != SIdle);
  assign cfg_ready_o = 1'b1;
  assign cfg_we   = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_rows_q   <= 8'(MaxRows);
      base_cols_q   <= 8'(MaxCols);
      level_count_q <= 3'd3;
    end else if (cfg_we) begin
      case (cfg_index_i)
        RegBaseRows:   base_rows_q   <= cfg_data_i;
        RegBaseCols:   base_cols_q   <= cfg_data_i;
        RegLevelCount: level_count_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // Level sizes latched at build start
  always_comb begin
    br = base_rows_q;
    if (br == 8'd0) br = 8'd1;
    if (br > 8'(MaxRows)) br = 8'(MaxRows);
    bc = base_cols_q;
    if (bc == 8'd0) bc = 8'd1;
    if (bc > 8'(MaxCols)) bc = 8'(MaxCols);
    lc = level_count_q;
    rr = br;
    cc = bc;
    rows_d[0] = br;
    cols_d[0] = bc;
    for (int k = 1; k <= MaxLevels; k++) begin
      rr = 8'((9'(rr) + 9'd1) >> 1);
      cc = 8'((9'(cc) + 9'd1) >> 1);
      rows_d[k] = (3'(k) <= lc) ? rr : 8'd0;
      cols_d[k] = (3'(k) <= lc) ? cc : 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= MaxLevels; k++) begin
        rows_q[k] <= 8'd0;
        cols_q[k] <= 8'd0;
      end
      lc_q <= 3'd0;
    end else if (is_build) begin
      for (int k = 0; k <= MaxLevels; k++) begin
        rows_q[k] <= rows_d[k];
        cols_q[k] <= cols_d[k];
      end
      lc_q <= lc;
    end
  end

  // Tap address generation
  always_comb begin
    cur_rows = rows_q[lvl_q];
    cur_cols = cols_q[lvl_q];
    yend = 8'({cur_rows - 8'd1, 1'b0});
    xend = 8'({cur_cols - 8'd1, 1'b0});
    vy = 8'({i_q, 1'b0}) + 8'(dy_q);
    vx = 8'({j_q, 1'b0}) + 8'(dx_q);
    y = (vy < 8'd2) ? 8'd0 : vy - 8'd2;
    if (y > yend) y = yend;
    x = (vx < 8'd2) ? 8'd0 : vx - 8'd2;
    if (x > xend) x = xend;
    src = lvl_q - 3'd1;
    src_addr = level_offset(src)
             + (AddrBits'(y[RowBits-1:0]) << (3'(ColBits) - src))
             + AddrBits'(x[ColBits-1:0]);
    dst_addr = level_offset(lvl_q)
             + (AddrBits'(i_q) << (3'(ColBits) - lvl_q))
             + AddrBits'(j_q);
    rd_addr = level_offset(cmd_i.level)
            + (AddrBits'(cmd_i.row) << (3'(ColBits) - cmd_i.level))
            + AddrBits'(cmd_i.col);
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    lvl_d = lvl_q;
    i_d = i_q;
    j_d = j_q;
    dy_d = dy_q;
    dx_d = dx_q;
    case (state_q)
      SIdle: begin
        if (is_build && lc != 3'd0) begin
          state_d = SRun;
          lvl_d = 3'd1;
          i_d = '0;
          j_d = '0;
          dy_d = 3'd0;
          dx_d = 3'd0;
        end
      end
      SRun: begin
        if (dx_q != 3'd4) begin
          dx_d = dx_q + 3'd1;
        end else begin
          dx_d = 3'd0;
          if (dy_q != 3'd4) begin
            dy_d = dy_q + 3'd1;
          end else begin
            dy_d = 3'd0;
            if (8'(j_q) != cur_cols - 8'd1) begin
              j_d = j_q + 1'b1;
            end else begin
              j_d = '0;
              if (8'(i_q) != cur_rows - 8'd1) begin
                i_d = i_q + 1'b1;
              end else begin
                i_d = '0;
                state_d = SDrain;
              end
            end
          end
        end
      end
      SDrain: begin
        if (tap_vld_q && last_q) begin
          if (lvl_q == lc_q) begin
            state_d = SIdle;
          end else begin
            lvl_d = lvl_q + 3'd1;
            state_d = SRun;
          end
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      lvl_q <= 3'd0;
      i_q <= '0;
      j_q <= '0;
      dy_q <= 3'd0;
      dx_q <= 3'd0;
      tap_vld_q <= 1'b0;
      rd_pend_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      lvl_q <= lvl_d;
      i_q <= i_d;
      j_q <= j_d;
      dy_q <= dy_d;
      dx_q <= dx_d;
      tap_vld_q <= (state_q == SRun);
      rd_pend_q <= is_read;
      done_q <= (is_build && lc == 3'd0)
             || (state_q == SDrain && tap_vld_q && last_q && lvl_q == lc_q);
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= (dy_q == 3'd0) && (dx_q == 3'd0);
    last_q  <= (dy_q == 3'd4) && (dx_q == 3'd4);
    w_q     <= weight(dy_q, dx_q);
    waddr_q <= dst_addr;
    if (tap_vld_q) begin
      acc_q <= mac;
    end
  end

  assign mac = (first_q ? '0 : acc_q) + AccBits'(w_q) * AccBits'(rdata);
  assign rnd = (AccBits+1)'(mac) + (AccBits+1)'(128);
  assign build_wr = tap_vld_q && last_q;

  assign mem_we    = is_load || build_wr;
  assign mem_waddr = build_wr ? waddr_q : level_offset(3'd0)
                   + (AddrBits'(cmd_i.row) << ColBits) + AddrBits'(cmd_i.col);
  assign mem_wdata = build_wr ? rnd[PixelBits+7:8] : cmd_i.pixel_in;
  assign mem_raddr = (state_q == SRun) ? src_addr : rd_addr;

  gipb_store u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (rdata)
  );

  // Read answer
  assign q_rows = rows_q[cmd_i.level];
  assign q_cols = cols_q[cmd_i.level];

  always_ff @(posedge clk_i) begin
    if (is_read) begin
      rd_rows_q <= q_rows;
      rd_cols_q <= q_cols;
      rd_oor_q  <= !((8'(cmd_i.row) < q_rows) && (8'(cmd_i.col) < q_cols));
    end
  end

  assign res_strobe_o = rd_pend_q || done_q;

  always_comb begin
    res_o = '0;
    if (rd_pend_q) begin
      res_o.is_read_data = 1'b1;
      res_o.pixel_out    = rd_oor_q ? '0 : rdata;
      res_o.level_rows   = rd_rows_q;
      res_o.level_cols   = rd_cols_q;
      res_o.out_of_range = rd_oor_q;
    end
  end

endmodule

// File: rtl/core/gipb_store.sv
// Pyramid pixel store: one write port, one read port, registered read data.
// Depends on gipb_pkg.
module gipb_store (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [gipb_pkg::AddrBits-1:0] waddr_i,
  input  logic [gipb_pkg::PixelBits-1:0] wdata_i,
  input  logic [gipb_pkg::AddrBits-1:0] raddr_i,
  output logic [gipb_pkg::PixelBits-1:0] rdata_o
);
  import gipb_pkg::*;

  logic [PixelBits-1:0] mem [StoreDepth];
  logic [PixelBits-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/gipb_checker.sv
// Port-level checker for the pyramid builder, bound to the top level.
// Depends on gipb_pkg and gaussian_image_pyramid_builder.
module gipb_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input logic           busy_o,
  input gipb_pkg::cmd_t cmd_i,
  input logic           res_strobe_o,
  input gipb_pkg::res_t res_o
);
  import gipb_pkg::*;

  logic acc;
  assign acc = start_i && !busy_o;

  a_read_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && cmd_i.action == ActRead |=> res_strobe_o && res_o.is_read_data)
    else $error("read beat not answered");

  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && cmd_i.action == ActLoad |=> !res_strobe_o)
    else $error("load beat produced a result");

  a_build_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && cmd_i.action == ActBuild |=> busy_o || (res_strobe_o && !res_o.is_read_data))
    else $error("build neither busy nor done");

  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && !res_o.is_read_data |-> res_o.pixel_out == '0
      && res_o.level_rows == 8'd0 && res_o.level_cols == 8'd0 && !res_o.out_of_range)
    else $error("build-done beat carries data");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && res_o.out_of_range |-> res_o.pixel_out == '0)
    else $error("out-of-range read returned a pixel");

endmodule

bind gaussian_image_pyramid_builder gipb_checker u_gipb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .cmd_i        (cmd_i),
  .res_strobe_o (res_strobe_o),
  .res_o        (res_o)
);

// File: tb/tb.sv
// Testbench for gaussian_image_pyramid_builder: loads base images, builds pyramids
// and reads them back, checking every result against a built-in pyramid predictor.
// Depends on gipb_pkg and the block's RTL.
`timescale 1ns / 100ps

import gipb_pkg::*;

class pyramid_scoreboard;
  logic [PixelBits-1:0] pix [StoreDepth];
  int unsigned          lvl_base [MaxLevels+1];
  int unsigned          lvl_stride [MaxLevels+1];
  int unsigned          rows_of [MaxLevels+1];
  int unsigned          cols_of [MaxLevels+1];
  int unsigned          reg_rows;
  int unsigned          reg_cols;
  int unsigned          reg_levels;
  res_t                 due_q [$];
  int                   errors;

  function new();
    int unsigned off, r, c;
    off = 0;
    r = MaxRows;
    c = MaxCols;
    for (int k = 0; k <= MaxLevels; k++) begin
      rows_of[k] = 0;
      cols_of[k] = 0;
      lvl_base[k] = off;
      lvl_stride[k] = c;
      off += r * c;
      r = (r + 1) >> 1;
      c = (c + 1) >> 1;
    end
    reg_rows = 128;
    reg_cols = 128;
    reg_levels = 3;
    errors = 0;
  endfunction

  function int pending();
    return due_q.size();
  endfunction

  function void report(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endfunction

  function void note_cfg(logic [1:0] idx, logic [7:0] data);
    case (idx)
      RegBaseRows:   reg_rows = data;
      RegBaseCols:   reg_cols = data;
      RegLevelCount: reg_levels = data[2:0];
      default: ;
    endcase
  endfunction

  function int unsigned addr(int unsigned k, int unsigned r, int unsigned c);
    return lvl_base[k] + r * lvl_stride[k] + c;
  endfunction

  function void build_levels();
    int unsigned br, bc, lc, rs, cs;
    int          yend, xend, y, x;
    longint unsigned acc;
    br = (reg_rows < 1) ? 1 : (reg_rows > MaxRows) ? MaxRows : reg_rows;
    bc = (reg_cols < 1) ? 1 : (reg_cols > MaxCols) ? MaxCols : reg_cols;
    lc = (reg_levels > MaxLevels) ? MaxLevels : reg_levels;
    for (int k = 0; k <= MaxLevels; k++) begin
      rows_of[k] = 0;
      cols_of[k] = 0;
    end
    rows_of[0] = br;
    cols_of[0] = bc;
    for (int k = 1; k <= lc; k++) begin
      rs = (rows_of[k-1] + 1) >> 1;
      cs = (cols_of[k-1] + 1) >> 1;
      yend = 2 * (int'(rs) - 1);
      xend = 2 * (int'(cs) - 1);
      rows_of[k] = rs;
      cols_of[k] = cs;
      for (int i = 0; i < rs; i++) begin
        for (int j = 0; j < cs; j++) begin
          acc = 0;
          for (int dy = -2; dy <= 2; dy++) begin
            y = 2 * i + dy;
            y = (y < 0) ? 0 : (y > yend) ? yend : y;
            for (int dx = -2; dx <= 2; dx++) begin
              x = 2 * j + dx;
              x = (x < 0) ? 0 : (x > xend) ? xend : x;
              acc += longint'(tap(dy) * tap(dx)) * pix[addr(k - 1, y, x)];
            end
          end
          pix[addr(k, i, j)] = PixelBits'((acc + 128) >> 8);
        end
      end
    end
  endfunction

  function int tap(int d);
    case (d)
      -2, 2: return 1;
      -1, 1: return 4;
      default: return 6;
    endcase
  endfunction

  function void note_cmd(cmd_t c);
    res_t r;
    r = '0;
    case (c.action)
      ActLoad: pix[addr(0, c.row, c.col)] = c.pixel_in;
      ActBuild: begin
        build_levels();
        due_q.push_back(r);
      end
      ActRead: begin
        r.is_read_data = 1'b1;
        r.level_rows = 8'(rows_of[c.level]);
        r.level_cols = 8'(cols_of[c.level]);
        if (c.row < rows_of[c.level] && c.col < cols_of[c.level])
          r.pixel_out = pix[addr(c.level, c.row, c.col)];
        else
          r.out_of_range = 1'b1;
        due_q.push_back(r);
      end
      default: ;
    endcase
  endfunction

  function void check_result(res_t got);
    res_t w;
    if (due_q.size() == 0) begin
      report("result with nothing expected");
      return;
    end
    w = due_q.pop_front();
    if (got.is_read_data !== w.is_read_data)
      report($sformatf("is_read_data %0b, want %0b", got.is_read_data, w.is_read_data));
    if (got.pixel_out !== w.pixel_out)
      report($sformatf("pixel_out %0h, want %0h", got.pixel_out, w.pixel_out));
    if (got.level_rows !== w.level_rows)
      report($sformatf("level_rows %0d, want %0d", got.level_rows, w.level_rows));
    if (got.level_cols !== w.level_cols)
      report($sformatf("level_cols %0d, want %0d", got.level_cols, w.level_cols));
    if (got.out_of_range !== w.out_of_range)
      report($sformatf("out_of_range %0b, want %0b", got.out_of_range, w.out_of_range));
  endfunction
endclass

module tb;
  logic       clk_i;
  logic       rst_ni;
  logic       start_i;
  logic       busy_o;
  cmd_t       cmd_i;
  logic       res_strobe_o;
  res_t       res_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [7:0] cfg_data_i;

  pyramid_scoreboard sb;
  bit                quiet;
  int unsigned       cycles;

  gaussian_image_pyramid_builder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .cmd_i        (cmd_i),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_strobe_o) sb.check_result(res_o);
  end

  task automatic send_beat(input cmd_t c);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy_o);
    sb.note_cmd(c);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0 || busy_o) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.note_cfg(idx, data);
  endtask

  function automatic cmd_t mk(logic [1:0] a, int lv, int r, int c, int p);
    cmd_t x;
    x.action = a;
    x.level = 3'(lv);
    x.row = RowBits'(r);
    x.col = ColBits'(c);
    x.pixel_in = PixelBits'(p);
    return x;
  endfunction

  function automatic int rand_pixel();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 65535;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  task automatic run_phase(input int rv, input int cv, input int lc, input int nreads);
    int br, bc, lv;
    drain();
    write_reg(RegBaseRows, 8'(rv));
    write_reg(RegBaseCols, 8'(cv));
    write_reg(RegLevelCount, 8'(lc));
    br = (rv < 1) ? 1 : (rv > MaxRows) ? MaxRows : rv;
    bc = (cv < 1) ? 1 : (cv > MaxCols) ? MaxCols : cv;
    for (int r = 0; r < br; r++) begin
      for (int c = 0; c < bc; c++) begin
        send_beat(mk(ActLoad, $urandom_range(0, 7), r, c, rand_pixel()));
        if ($urandom_range(0, 15) == 0)
          send_beat(mk($urandom_range(0, 1) ? ActNone : ActLoad, $urandom_range(0, 7),
                       $urandom_range(0, 127), $urandom_range(0, 127), rand_pixel()));
      end
    end
    send_beat(mk(ActBuild, $urandom_range(0, 7), $urandom_range(0, 127),
                 $urandom_range(0, 127), $urandom_range(0, 65535)));
    for (int n = 0; n < nreads; n++) begin
      case ($urandom_range(0, 19))
        0: send_beat(mk(ActLoad, 0, $urandom_range(0, br - 1), $urandom_range(0, bc - 1),
                        rand_pixel()));
        1: send_beat(mk(ActBuild, 0, 0, 0, 0));
        2: send_beat(mk(ActNone, 0, 0, 0, 0));
        3, 4: send_beat(mk(ActRead, $urandom_range(0, 7), $urandom_range(0, 127),
                           $urandom_range(0, 127), rand_pixel()));
        default: begin
          lv = $urandom_range(0, (lc > MaxLevels) ? MaxLevels : lc);
          send_beat(mk(ActRead, lv,
                       $urandom_range(0, (sb.rows_of[lv] > 0) ? sb.rows_of[lv] - 1 : 0),
                       $urandom_range(0, (sb.cols_of[lv] > 0) ? sb.cols_of[lv] - 1 : 0),
                       $urandom_range(0, 65535)));
        end
      endcase
    end
  endtask

  initial begin
    sb = new();
    quiet = 1'b0;
    cycles = 0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    cmd_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_beat(mk(ActRead, 0, 0, 0, 0));
    send_beat(mk(ActRead, 7, 127, 127, 65535));
    send_beat(mk(ActNone, 7, 127, 127, 65535));
    drain();
    write_reg(RegBaseRows, 8'd0);
    write_reg(RegBaseCols, 8'd1);
    write_reg(RegLevelCount, 8'd7);
    send_beat(mk(ActLoad, 0, 0, 0, 65535));
    send_beat(mk(ActLoad, 0, 127, 127, 0));
    send_beat(mk(ActBuild, 0, 0, 0, 0));
    for (int k = 0; k <= MaxLevels; k++) send_beat(mk(ActRead, k, 0, 0, 0));
    send_beat(mk(ActRead, 0, 1, 0, 0));
    send_beat(mk(ActRead, 1, 0, 1, 0));
    drain();
    write_reg(RegBaseRows, 8'd2);
    write_reg(RegBaseCols, 8'd3);
    write_reg(RegLevelCount, 8'd1);
    send_beat(mk(ActLoad, 0, 0, 0, 65535));
    send_beat(mk(ActLoad, 0, 0, 1, 0));
    send_beat(mk(ActLoad, 0, 0, 2, 65535));
    send_beat(mk(ActLoad, 0, 1, 0, 0));
    send_beat(mk(ActLoad, 0, 1, 1, 65535));
    send_beat(mk(ActLoad, 0, 1, 2, 1));
    send_beat(mk(ActBuild, 0, 0, 0, 0));
    send_beat(mk(ActRead, 1, 0, 0, 0));
    send_beat(mk(ActRead, 1, 0, 1, 0));
    send_beat(mk(ActRead, 2, 0, 0, 0));

    for (int p = 0; p < 8; p++) begin
      if (p == 3)
        run_phase(255, 1, 7, 20);
      else
        run_phase($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8),
                  $urandom_range(1, 8), $urandom_range(0, 7), $urandom_range(15, 30));
      if (p == 5) quiet = 1'b1;
    end
    run_phase(1, 128, 0, 20);
    run_phase(9, 5, 2, 20);

    drain();
    if (sb.pending() != 0) sb.report("expected results never arrived");
    if (sb.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule
